### hdl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types and constants for the luminance palette recolor block.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int CHAN_W   = 8;
  localparam int COLOR_W  = 3 * CHAN_W;
  localparam int LANES    = 3;
  localparam int IDX_W    = 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // floor(s / 3) == (s * 683) >> 11 for every s below 2048
  localparam int SUM_W      = CHAN_W + 2;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_W     = SUM_W + 10;

  // reciprocal of the blend divisor: ceil(2^24 / d), exact for numerators < 2^16
  localparam int RCP_SHIFT = 24;
  localparam int RCP_W     = RCP_SHIFT + 1;
  localparam int NUM_W     = 2 * CHAN_W + 1;
  localparam int PROD_W    = NUM_W + RCP_W;
  localparam int Q_W       = PROD_W - RCP_SHIFT;

  typedef enum logic [IDX_W-1:0] {
    REG_MID_COLOR = 2'd0,
    REG_MAX_COLOR = 2'd1,
    REG_MIN_COLOR = 2'd2,
    REG_REF_LEVEL = 2'd3
  } cfg_idx_t;

  // per-pixel blend control, shared by all lanes
  typedef struct packed {
    logic              vld;
    logic              lower;
    logic [CHAN_W-1:0] wa;
    logic [CHAN_W-1:0] wb;
    logic [RCP_W-1:0]  rcp;
  } ctl_t;

  typedef struct packed {
    logic           vld;
    logic [Q_W-1:0] q;
  } lane_res_t;

endpackage

### hdl/lrc_luma.sv
// ----------------------------------------------------------------------------
// lrc_luma
// Brightness of the pixel, blend selection, weights and divisor reciprocal.
// ----------------------------------------------------------------------------
module lrc_luma (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  logic [lrc_pkg::CHAN_W-1:0] red,
  input  logic [lrc_pkg::CHAN_W-1:0] green,
  input  logic [lrc_pkg::CHAN_W-1:0] blue,
  input  logic [lrc_pkg::CHAN_W-1:0] ref_lvl,
  output lrc_pkg::ctl_t            ctl
);
  import lrc_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [DIV3_W-1:0] sum_x3;
  logic [CHAN_W-1:0] luma_r, luma_nxt;
  logic              s1_vld_r;
  logic              lower;
  logic [CHAN_W-1:0] div;
  logic [RCP_W-1:0]  rcp_tab [2**CHAN_W];
  ctl_t              ctl_r, ctl_nxt;

  // reciprocal table, divisor zero never selected
  assign rcp_tab[0] = '0;
  for (genvar g = 1; g < 2**CHAN_W; g++) begin : g_rcp
    localparam longint RCP = ((longint'(1) << RCP_SHIFT) + g - 1) / g;
    assign rcp_tab[g] = RCP_W'(RCP);
  end

  // stage 1: floored mean of the three channels
  always_comb begin
    sum      = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    sum_x3   = DIV3_W'(sum) * DIV3_W'(DIV3_MUL);
    luma_nxt = sum_x3[DIV3_SHIFT +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
    luma_r <= luma_nxt;
  end

  // stage 2: pick the blend segment
  always_comb begin
    lower = (ref_lvl != '0) && (luma_r <= ref_lvl);
    ctl_nxt.vld   = s1_vld_r;
    ctl_nxt.lower = lower;
    if (lower) begin
      ctl_nxt.wa = luma_r;
      ctl_nxt.wb = ref_lvl - luma_r;
      div        = ref_lvl;
    end else begin
      ctl_nxt.wa = CHAN_MAX - luma_r;
      ctl_nxt.wb = luma_r - ref_lvl;
      div        = CHAN_MAX - ref_lvl;
    end
    ctl_nxt.rcp = rcp_tab[div];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  assign ctl = ctl_r;

  // divisor is never zero for an item in flight
  a_rcp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.vld |-> ctl_r.rcp != '0)
    else $error("zero divisor reached blend lanes");

endmodule

### hdl/lrc_lane.sv
// ----------------------------------------------------------------------------
// lrc_lane
// One color channel: weighted sum of two palette colors, then reciprocal divide.
// ----------------------------------------------------------------------------
module lrc_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrc_pkg::ctl_t              ctl,
  input  logic [lrc_pkg::CHAN_W-1:0] mid_c,
  input  logic [lrc_pkg::CHAN_W-1:0] min_c,
  input  logic [lrc_pkg::CHAN_W-1:0] max_c,
  output lrc_pkg::lane_res_t         res
);
  import lrc_pkg::*;

  logic [CHAN_W-1:0] cb;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [RCP_W-1:0]  rcp_r;
  logic              num_vld_r;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_r;
  logic              q_vld_r;

  always_comb begin
    cb      = ctl.lower ? min_c : max_c;
    num_nxt = NUM_W'(ctl.wa) * NUM_W'(mid_c) + NUM_W'(ctl.wb) * NUM_W'(cb);
  end

  always_comb begin
    prod = PROD_W'(num_r) * PROD_W'(rcp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vld_r <= 1'b0;
      q_vld_r   <= 1'b0;
    end else begin
      num_vld_r <= ctl.vld;
      q_vld_r   <= num_vld_r;
    end
    num_r <= num_nxt;
    rcp_r <= ctl.rcp;
    q_r   <= prod[RCP_SHIFT +: Q_W];
  end

  assign res.vld = q_vld_r;
  assign res.q   = q_r;

  // convex blend: quotient fits a channel
  a_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_vld_r |-> q_r <= Q_W'(CHAN_MAX))
    else $error("blend quotient above channel range");

endmodule

### hdl/lrc_merge.sv
// ----------------------------------------------------------------------------
// lrc_merge
// Collects the lane quotients, saturates them and drives the result registers.
// ----------------------------------------------------------------------------
module lrc_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lrc_pkg::lane_res_t         res [lrc_pkg::LANES],
  output logic                       strobe,
  output logic [lrc_pkg::CHAN_W-1:0] chan [lrc_pkg::LANES]
);
  import lrc_pkg::*;

  logic              strobe_r;
  logic [CHAN_W-1:0] chan_r   [LANES];
  logic [CHAN_W-1:0] chan_nxt [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      chan_nxt[i] = (res[i].q > Q_W'(CHAN_MAX)) ? CHAN_MAX : res[i].q[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res[0].vld;
    end
    chan_r <= chan_nxt;
  end

  assign strobe = strobe_r;
  assign chan   = chan_r;

endmodule

### hdl/luminance_palette_recolor.sv
// ----------------------------------------------------------------------------
// luminance_palette_recolor
// Recolors one RGB pixel per clock by its brightness against a three-color
// palette (min, mid, max) split at a programmable reference level.
// ----------------------------------------------------------------------------
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ---------------------------
//  input    in_red_in, in_green_in, in_blue_in      start high while busy low
//  result   out_red_out, out_green_out, out_blue_out out_strobe, one cycle
//  config   cfg_index, cfg_data                     cfg_valid and cfg_ready
//
//  - one transaction per clock, every cycle outside reset
//  - the pipeline is brightness, segment select and reciprocal lookup, lane
//    multiply-add, lane reciprocal multiply, saturate and register
//  - rst_n is synchronous; busy is high and cfg_ready low while it is asserted
//  - the receiver cannot stall, so nothing ever holds the pipeline
//
module luminance_palette_recolor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lrc_pkg::CHAN_W-1:0] in_red_in,
  input  logic [lrc_pkg::CHAN_W-1:0] in_green_in,
  input  logic [lrc_pkg::CHAN_W-1:0] in_blue_in,
  output logic                       out_strobe,
  output logic [lrc_pkg::CHAN_W-1:0] out_red_out,
  output logic [lrc_pkg::CHAN_W-1:0] out_green_out,
  output logic [lrc_pkg::CHAN_W-1:0] out_blue_out,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lrc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [lrc_pkg::COLOR_W-1:0] cfg_data
);
  import lrc_pkg::*;

  localparam int LAT = 5;

  // configuration registers
  logic [COLOR_W-1:0] mid_color_r;
  logic [COLOR_W-1:0] max_color_r;
  logic [COLOR_W-1:0] min_color_r;
  logic [CHAN_W-1:0]  ref_level_r;
  logic               cfg_wr;

  logic               in_acc;
  ctl_t               ctl;
  lane_res_t          lane_res [LANES];
  logic [CHAN_W-1:0]  out_chan [LANES];

  // the pipeline never stalls; only reset holds off transactions
  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign in_acc    = start & ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_color_r <= '0;
      max_color_r <= '0;
      min_color_r <= '0;
      ref_level_r <= CHAN_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MID_COLOR: mid_color_r <= cfg_data;
        REG_MAX_COLOR: max_color_r <= cfg_data;
        REG_MIN_COLOR: min_color_r <= cfg_data;
        REG_REF_LEVEL: ref_level_r <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // brightness and blend segment, shared by all lanes
  lrc_luma u_luma (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .red     (in_red_in),
    .green   (in_green_in),
    .blue    (in_blue_in),
    .ref_lvl (ref_level_r),
    .ctl     (ctl)
  );

  // one lane per color channel, red in the top byte of each palette color
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int SH = (LANES - 1 - k) * CHAN_W;
    lrc_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .mid_c (mid_color_r[SH +: CHAN_W]),
      .min_c (min_color_r[SH +: CHAN_W]),
      .max_c (max_color_r[SH +: CHAN_W]),
      .res   (lane_res[k])
    );
  end

  // saturate and present the recolored pixel
  lrc_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .res    (lane_res),
    .strobe (out_strobe),
    .chan   (out_chan)
  );

  assign out_red_out   = out_chan[0];
  assign out_green_out = out_chan[1];
  assign out_blue_out  = out_chan[2];

  // every accepted transaction gives exactly one strobe, a fixed latency later
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe == $past(in_acc & rst_n, LAT))
    else $error("result strobe does not match accepted transactions");

  // lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lane_res[0].vld == lane_res[1].vld && lane_res[0].vld == lane_res[2].vld)
    else $error("lane valids out of step");

endmodule

### tb/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker
// Watches the pixel, result and register channels of the recolor block,
// predicts every recolored pixel from a shadow of the palette registers and
// compares each result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lrc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [lrc_pkg::CHAN_W-1:0]  in_red_in,
  input  logic [lrc_pkg::CHAN_W-1:0]  in_green_in,
  input  logic [lrc_pkg::CHAN_W-1:0]  in_blue_in,
  input  logic                        out_strobe,
  input  logic [lrc_pkg::CHAN_W-1:0]  out_red_out,
  input  logic [lrc_pkg::CHAN_W-1:0]  out_green_out,
  input  logic [lrc_pkg::CHAN_W-1:0]  out_blue_out,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [lrc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lrc_pkg::COLOR_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import lrc_pkg::*;

  typedef struct {
    logic [COLOR_W-1:0] src;
    logic [COLOR_W-1:0] color;
  } recolor_exp_t;

  logic [COLOR_W-1:0] mid_q;
  logic [COLOR_W-1:0] max_q;
  logic [COLOR_W-1:0] min_q;
  logic [CHAN_W-1:0]  level_q;

  recolor_exp_t expected_colors[$];
  int           errs = 0;

  function automatic logic [CHAN_W-1:0] blend_floor(input int num, input int div);
    int q;
    q = num / div;
    return (q > int'(CHAN_MAX)) ? CHAN_MAX : CHAN_W'(q);
  endfunction

  // brightness split at the reference level: lower segment min..mid,
  // upper segment mid..max
  function automatic logic [COLOR_W-1:0] recolor(input logic [COLOR_W-1:0] src);
    int                 lum;
    int                 lvl;
    int                 sh;
    int                 mid_c;
    logic [COLOR_W-1:0] res;
    lum = (int'(src[23:16]) + int'(src[15:8]) + int'(src[7:0])) / 3;
    lvl = int'(level_q);
    res = '0;
    for (int k = 0; k < LANES; k++) begin
      sh    = 16 - 8 * k;
      mid_c = int'(mid_q[sh +: CHAN_W]);
      if (lvl != 0 && lum <= lvl) begin
        res[sh +: CHAN_W] = blend_floor(lum * mid_c + (lvl - lum) * int'(min_q[sh +: CHAN_W]),
                                        lvl);
      end else begin
        res[sh +: CHAN_W] = blend_floor((int'(CHAN_MAX) - lum) * mid_c
                                        + (lum - lvl) * int'(max_q[sh +: CHAN_W]),
                                        int'(CHAN_MAX) - lvl);
      end
    end
    return res;
  endfunction

  task automatic flag(input string msg);
    errs++;
    if (errs <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin
    recolor_exp_t       want;
    logic [COLOR_W-1:0] got;
    string              lane_name[LANES];
    int                 sh;
    lane_name = '{"red_out", "green_out", "blue_out"};
    if (!rst_n) begin
      mid_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      level_q <= CHAN_MAX;
      expected_colors.delete();
      pending <= 0;
    end else begin
      // result side first, so a same-edge transaction never pairs with itself
      if (out_strobe === 1'b1) begin
        got = {out_red_out, out_green_out, out_blue_out};
        if (expected_colors.size() == 0) begin
          flag($sformatf("result %06h with no pixel outstanding", got));
        end else begin
          want = expected_colors.pop_front();
          for (int k = 0; k < LANES; k++) begin
            sh = 16 - 8 * k;
            if (got[sh +: CHAN_W] !== want.color[sh +: CHAN_W]) begin
              flag($sformatf("%s for pixel %06h: expected %0d got %0d", lane_name[k],
                             want.src, want.color[sh +: CHAN_W], got[sh +: CHAN_W]));
            end
          end
        end
      end else if (out_strobe !== 1'b0) begin
        flag("out_strobe unknown");
      end

      if (start === 1'b1 && busy === 1'b0) begin
        want.src   = {in_red_in, in_green_in, in_blue_in};
        want.color = recolor(want.src);
        expected_colors.push_back(want);
      end

      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_idx_t'(cfg_index))
          REG_MID_COLOR: mid_q   <= cfg_data;
          REG_MAX_COLOR: max_q   <= cfg_data;
          REG_MIN_COLOR: min_q   <= cfg_data;
          REG_REF_LEVEL: level_q <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end

      pending <= expected_colors.size();
    end
    fail_count <= errs;
  end

endmodule

### tb/tb_luminance_palette_recolor.sv
// ----------------------------------------------------------------------------
// tb_luminance_palette_recolor
// Drives pixels and palette writes into the recolor block with random gaps;
// a checker beside the block predicts and compares every recolored pixel.
// ----------------------------------------------------------------------------
module tb_luminance_palette_recolor;
  import lrc_pkg::*;

  // generous bound for ~1000 pixels with the occasional long gap
  localparam int CYCLE_LIMIT  = 200000;
  // margin after the last result for stray strobes
  localparam int SETTLE_CYCLES = 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 125;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [CHAN_W-1:0]  in_red_in;
  logic [CHAN_W-1:0]  in_green_in;
  logic [CHAN_W-1:0]  in_blue_in;
  logic               out_strobe;
  logic [CHAN_W-1:0]  out_red_out;
  logic [CHAN_W-1:0]  out_green_out;
  logic [CHAN_W-1:0]  out_blue_out;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [COLOR_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int cycle_count;

  luminance_palette_recolor dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_strobe    (out_strobe),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // prediction and comparison live entirely in the checker
  lrc_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_strobe    (out_strobe),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CHAN_W-1:0] clamp_chan(input int v);
    if (v < 0) return '0;
    if (v > int'(CHAN_MAX)) return CHAN_MAX;
    return CHAN_W'(v);
  endfunction

  // palette colors lean on the all-zero and all-one extremes now and then
  function automatic logic [COLOR_W-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom);
    endcase
  endfunction

  // holds start with the pixel until the block takes the transaction; start
  // stays high when no gap follows so back-to-back pixels stream through
  task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b, input int gap);
    start       <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (busy !== 1'b0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding pixel come back
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [COLOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // only called with the pipeline empty; junk above bit 7 of the level write
  // checks that the register keeps just its low byte
  task automatic program_palette(input logic [COLOR_W-1:0] mid, input logic [COLOR_W-1:0] max,
                                 input logic [COLOR_W-1:0] min, input logic [CHAN_W-1:0] lvl);
    cfg_write(REG_MID_COLOR, mid);
    cfg_write(REG_MAX_COLOR, max);
    cfg_write(REG_MIN_COLOR, min);
    cfg_write(REG_REF_LEVEL, {16'($urandom), lvl});
    cfg_valid <= 1'b0;
  endtask

  // random pixel: half fully random, a quarter gray near the reference level
  // so both segments and the split point get hit, a quarter channel extremes
  task automatic send_random(input logic [CHAN_W-1:0] lvl, input bit steady);
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
    int                a;
    case ($urandom_range(0, 3))
      0, 1: begin
        r = CHAN_W'($urandom);
        g = CHAN_W'($urandom);
        b = CHAN_W'($urandom);
      end
      2: begin
        a = int'(lvl) + int'($urandom_range(0, 4)) - 2;
        g = clamp_chan(a);
        b = g;
        r = clamp_chan(int'(g) + int'($urandom_range(0, 2)) - 1);
      end
      default: begin
        r = $urandom_range(0, 1) ? CHAN_MAX : '0;
        g = $urandom_range(0, 1) ? CHAN_MAX : '0;
        b = $urandom_range(0, 1) ? CHAN_MAX : '0;
      end
    endcase
    send_pixel(r, g, b, steady ? 0 : pick_gap());
  endtask

  initial begin
    logic [CHAN_W-1:0] lvl;
    bit                steady;
    int                pause_at;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_MID_COLOR;
    cfg_data    <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset palette: level 255 and black everywhere
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 1);
    send_pixel(8'd90, 8'd180, 8'd45, 0);
    drain();

    // mid-level split: black, exact split, one step either side, full white
    program_palette(24'h40A0C0, 24'hFFFFFF, 24'h000000, 8'd128);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd128, 8'd128, 8'd128, 0);
    send_pixel(8'd129, 8'd129, 8'd129, 2);
    send_pixel(8'd127, 8'd127, 8'd128, 0);
    send_pixel(8'd255, 8'd255, 8'd254, 0);
    send_pixel(8'd1, 8'd1, 8'd0, 0);
    drain();

    // zero reference: upper segment for every brightness, divisor 255
    program_palette(24'h123456, 24'hFEDCBA, 24'hFFFFFF, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd1, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 3);
    send_pixel(8'd100, 8'd50, 8'd25, 0);
    drain();

    // full reference: lower segment always, upper divisor never zero
    program_palette(24'hFFFFFF, 24'h00FF00, 24'h000000, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd254, 8'd255, 8'd255, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    drain();

    // inverted palette with the level one step off each end
    program_palette(24'h5A3CF0, 24'h000000, 24'hFFFFFF, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd1, 0);
    send_pixel(8'd2, 8'd2, 8'd2, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    drain();
    program_palette(24'h5A3CF0, 24'h000000, 24'hFFFFFF, 8'd254);
    send_pixel(8'd254, 8'd254, 8'd254, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    drain();

    // random phases, each under a fresh palette; levels favor the edges
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       lvl = '0;
        1:       lvl = CHAN_MAX;
        2:       lvl = 8'd1;
        3:       lvl = 8'd254;
        default: lvl = CHAN_W'($urandom);
      endcase
      program_palette(pick_color(), pick_color(), pick_color(), lvl);
      steady   = ($urandom_range(0, 3) == 0);
      pause_at = $urandom_range(1, PHASE_ITEMS - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // hold off mid-phase until the pipeline runs dry
        if (i == pause_at) begin
          drain();
        end
        send_random(lvl, steady);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
